/* rtl/hmp_pkg.sv */
// Shared types and constants of the HID mouse to PS/2 packet converter.
package hmp_pkg;

	typedef enum logic [1:0] {
		REQ_REPORT = 2'd0,
		REQ_READ   = 2'd1,
		REQ_OPEN   = 2'd2,
		REQ_CLOSE  = 2'd3
	} req_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [2:0]        report_buttons;
		logic signed [7:0] report_dx;
		logic signed [7:0] report_dy;
		logic [1:0]        read_count;
	} in_item_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] out_byte;
		logic [1:0] byte_index;
		logic       open_status;
		logic       last;
		logic       data_ready;
	} out_item_t;

	typedef struct packed {
		req_t              op;
		logic [2:0]        buttons;
		logic signed [8:0] dx;
		logic signed [8:0] dy;
		logic [1:0]        count;
	} cmd_t;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_OPEN = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_NODEV = 1'b1;

	localparam logic [1:0] POS_BUTTONS = 2'd0;
	localparam logic [1:0] POS_X       = 2'd1;
	localparam logic [1:0] POS_Y       = 2'd2;

	localparam int XSIGN_BIT = 4;
	localparam int YSIGN_BIT = 5;

	localparam logic [7:0] OPEN_MAX = 8'hFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

endpackage

/* rtl/hid_mouse_to_ps2_packet_top.sv */
// Top level of the HID boot mouse to PS/2 packet converter.
//
//  Channel   Direction  Handshake           Payload
//  cfg       in         cfg_we              cfg_data (device_present)
//  req       in         req_valid/stall     hmp_pkg::in_item_t
//  rsp       out        rsp_valid/stall     hmp_pkg::out_item_t
//
// A request item is taken every cycle while the four-entry command queue has room.
// The front end drops empty reads. The back end retires a report or close without an item,
// an open with one status item and a read with one item per packet byte (one to three).
// Results appear in the cycle after execution, from a registered output stage.
// Reset is asynchronous and clears all mouse state and the device present register.
// A stall on rsp holds the back end only for commands that produce an item.
module hid_mouse_to_ps2_packet_top #(
	parameter int ACC_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_data,
	input  logic               req_valid,
	output logic               req_stall,
	input  hmp_pkg::in_item_t  req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output hmp_pkg::out_item_t rsp
);

	logic          dev_present_q;
	logic          push;
	logic          pop;
	logic          q_empty;
	logic          q_full;
	hmp_pkg::cmd_t cmd;
	hmp_pkg::cmd_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_present_q <= 1'b0;
		end else if (cfg_we) begin
			dev_present_q <= cfg_data;
		end
	end

	hmp_front u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.push      (push),
		.cmd       (cmd)
	);

	hmp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	hmp_back #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.device_present (dev_present_q),
		.empty          (q_empty),
		.head           (head),
		.pop            (pop),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp            (rsp)
	);

endmodule

/* rtl/hmp_front.sv */
// Front end: takes request items, decodes them into commands and drops empty reads.
module hmp_front (
	input  logic             req_valid,
	output logic             req_stall,
	input  hmp_pkg::in_item_t req,
	input  logic             q_full,
	output logic             push,
	output hmp_pkg::cmd_t    cmd
);

	hmp_pkg::req_t op;
	logic          empty_read;

	assign op         = hmp_pkg::req_t'(req.req_type);
	assign empty_read = (op == hmp_pkg::REQ_READ) && (req.read_count == 2'd0);
	assign req_stall  = q_full;
	assign push       = req_valid && !q_full && !empty_read;

	always_comb begin
		cmd.op      = op;
		cmd.buttons = req.report_buttons;
		cmd.dx      = 9'(req.report_dx);
		cmd.dy      = -(9'(req.report_dy));
		cmd.count   = req.read_count;
	end

endmodule

/* rtl/hmp_queue.sv */
// Short command queue between the front end and the execution back end.
module hmp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hmp_pkg::cmd_t push_data,
	input  logic          pop,
	output hmp_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	hmp_pkg::cmd_t                entry_q [hmp_pkg::QUEUE_DEPTH];
	logic [hmp_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [hmp_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [hmp_pkg::QCNT_W-1:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == hmp_pkg::QCNT_W'(hmp_pkg::QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + hmp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + hmp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + hmp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - hmp_pkg::QCNT_W'(1);
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= hmp_pkg::QCNT_W'(hmp_pkg::QUEUE_DEPTH))
		else $error("Queue count exceeds its depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("Queue popped while empty.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("Queue empty after a push.");

endmodule

/* rtl/hmp_back.sv */
// Back end: holds the mouse state, executes commands and registers result items.
module hmp_back #(
	parameter int ACC_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               device_present,
	input  logic               empty,
	input  hmp_pkg::cmd_t      head,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output hmp_pkg::out_item_t rsp
);

	localparam int AW = ACC_WIDTH;
	localparam logic [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

	logic [7:0]    open_cnt_q, open_cnt_d;
	logic [2:0]    latch_q, latch_d;
	logic [AW-1:0] acc_x_q, acc_x_d;
	logic [AW-1:0] acc_y_q, acc_y_d;
	logic [1:0]    pos_q, pos_d;
	logic          ready_q, ready_d;
	logic          rd_active_q, rd_active_d;
	logic [1:0]    rd_left_q, rd_left_d;
	logic          rsp_valid_q;
	hmp_pkg::out_item_t rsp_q;

	logic               out_free;
	logic               emit;
	hmp_pkg::out_item_t emit_item;
	logic [1:0]         left;
	logic [AW:0]        sum_x;
	logic [AW:0]        sum_y;
	logic [AW-1:0]      sat_x;
	logic [AW-1:0]      sat_y;
	logic [7:0]         btn_byte;
	logic               last_byte;

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign left     = rd_active_q ? rd_left_q : head.count;

	assign sum_x = {acc_x_q[AW-1], acc_x_q} + {{(AW-8){head.dx[8]}}, head.dx};
	assign sum_y = {acc_y_q[AW-1], acc_y_q} + {{(AW-8){head.dy[8]}}, head.dy};
	assign sat_x = (sum_x[AW] != sum_x[AW-1]) ? (sum_x[AW] ? ACC_MIN : ACC_MAX)
	                                          : sum_x[AW-1:0];
	assign sat_y = (sum_y[AW] != sum_y[AW-1]) ? (sum_y[AW] ? ACC_MIN : ACC_MAX)
	                                          : sum_y[AW-1:0];

	always_comb begin
		btn_byte                     = 8'(latch_q);
		btn_byte[hmp_pkg::XSIGN_BIT] = acc_x_q[AW-1];
		btn_byte[hmp_pkg::YSIGN_BIT] = acc_y_q[AW-1];
	end

	always_comb begin
		pop         = 1'b0;
		emit        = 1'b0;
		emit_item   = '0;
		last_byte   = 1'b0;
		open_cnt_d  = open_cnt_q;
		latch_d     = latch_q;
		acc_x_d     = acc_x_q;
		acc_y_d     = acc_y_q;
		pos_d       = pos_q;
		ready_d     = ready_q;
		rd_active_d = rd_active_q;
		rd_left_d   = rd_left_q;
		if (!empty) begin
			unique case (head.op)
				hmp_pkg::REQ_REPORT: begin
					pop = 1'b1;
					if (open_cnt_q != 8'd0) begin
						latch_d = head.buttons;
						acc_x_d = sat_x;
						acc_y_d = sat_y;
						ready_d = 1'b1;
					end
				end
				hmp_pkg::REQ_CLOSE: begin
					pop = 1'b1;
					if (open_cnt_q != 8'd0) begin
						open_cnt_d = open_cnt_q - 8'd1;
					end
				end
				hmp_pkg::REQ_OPEN: begin
					if (out_free) begin
						pop                  = 1'b1;
						emit                 = 1'b1;
						emit_item.out_kind   = hmp_pkg::KIND_OPEN;
						emit_item.last       = 1'b1;
						emit_item.data_ready = ready_q;
						if (!device_present) begin
							emit_item.open_status = hmp_pkg::STATUS_NODEV;
						end else begin
							emit_item.open_status = hmp_pkg::STATUS_OK;
							if (open_cnt_q == 8'd0) begin
								latch_d = '0;
								acc_x_d = '0;
								acc_y_d = '0;
							end
							if (open_cnt_q != hmp_pkg::OPEN_MAX) begin
								open_cnt_d = open_cnt_q + 8'd1;
							end
						end
					end
				end
				hmp_pkg::REQ_READ: begin
					if (out_free) begin
						emit                  = 1'b1;
						ready_d               = 1'b0;
						emit_item.out_kind    = hmp_pkg::KIND_BYTE;
						emit_item.open_status = hmp_pkg::STATUS_OK;
						emit_item.data_ready  = 1'b0;
						case (pos_q)
							hmp_pkg::POS_X: begin
								emit_item.out_byte   = acc_x_q[7:0];
								emit_item.byte_index = hmp_pkg::POS_X;
								acc_x_d              = '0;
								pos_d                = hmp_pkg::POS_Y;
								last_byte            = (left == 2'd1);
							end
							hmp_pkg::POS_Y: begin
								emit_item.out_byte   = acc_y_q[7:0];
								emit_item.byte_index = hmp_pkg::POS_Y;
								acc_y_d              = '0;
								pos_d                = hmp_pkg::POS_BUTTONS;
								last_byte            = 1'b1;
							end
							default: begin
								emit_item.out_byte   = btn_byte;
								emit_item.byte_index = hmp_pkg::POS_BUTTONS;
								latch_d              = '0;
								pos_d                = hmp_pkg::POS_X;
								last_byte            = (left == 2'd1);
							end
						endcase
						emit_item.last = last_byte;
						if (last_byte) begin
							pop         = 1'b1;
							rd_active_d = 1'b0;
						end else begin
							rd_active_d = 1'b1;
							rd_left_d   = left - 2'd1;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_cnt_q  <= '0;
			latch_q     <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			pos_q       <= hmp_pkg::POS_BUTTONS;
			ready_q     <= 1'b0;
			rd_active_q <= 1'b0;
			rd_left_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			open_cnt_q  <= open_cnt_d;
			latch_q     <= latch_d;
			acc_x_q     <= acc_x_d;
			acc_y_q     <= acc_y_d;
			pos_q       <= pos_d;
			ready_q     <= ready_d;
			rd_active_q <= rd_active_d;
			rd_left_q   <= rd_left_d;
			if (out_free) begin
				rsp_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			rsp_q <= emit_item;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_active_q |-> (!empty && head.op == hmp_pkg::REQ_READ))
		else $error("Read in progress without a read command at the queue head.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_active_q |-> (rd_left_q != 2'd0))
		else $error("Read in progress with no bytes left.");

	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != 2'd3)
		else $error("Packet position reached an unused value.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.out_kind == hmp_pkg::KIND_BYTE) |-> !rsp_q.data_ready)
		else $error("Packet byte item shows data ready.");

endmodule

/* tb/sv/hmp_packet_checker.sv */
// Checker that predicts the PS/2 packet results of the converter and compares them.
module hmp_packet_checker #(
	parameter int ACC_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_data,
	input  logic               req_valid,
	input  logic               req_stall,
	input  hmp_pkg::in_item_t  req,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  hmp_pkg::out_item_t rsp,
	input  logic               drain_done,
	output int                 outstanding,
	output int                 fail_count
);
	import hmp_pkg::*;

	logic                        dev_present;
	logic [7:0]                  open_cnt;
	logic [2:0]                  btn_latch;
	logic signed [ACC_WIDTH-1:0] acc_x;
	logic signed [ACC_WIDTH-1:0] acc_y;
	logic [1:0]                  pkt_pos;
	logic                        ready;
	bit                          leftover_checked;
	out_item_t                   ps2_result_q[$];

	task automatic report_mismatch(input string what);
		$display("[%0t] ps2 packet check: %s", $time, what);
		fail_count++;
	endtask

	function automatic logic signed [ACC_WIDTH-1:0] sat_add(
		input logic signed [ACC_WIDTH-1:0] acc, input longint delta);
		longint hi;
		longint lo;
		longint sum;
		hi = (longint'(1) << (ACC_WIDTH - 1)) - 1;
		lo = -hi - 1;
		sum = longint'(acc) + delta;
		if (sum > hi) begin
			sum = hi;
		end else if (sum < lo) begin
			sum = lo;
		end
		return sum[ACC_WIDTH-1:0];
	endfunction

	task automatic apply_host_request(input in_item_t it);
		logic [1:0] remaining;
		logic [1:0] pos;
		logic [7:0] b;
		logic       stop;
		logic       status;
		out_item_t  r;
		case (req_t'(it.req_type))
			REQ_REPORT: begin
				if (open_cnt != 0) begin
					btn_latch = it.report_buttons;
					acc_x = sat_add(acc_x, longint'($signed(it.report_dx)));
					acc_y = sat_add(acc_y, -longint'($signed(it.report_dy)));
					ready = 1'b1;
				end
			end
			REQ_READ: begin
				if (it.read_count != 0) begin
					ready = 1'b0;
					remaining = it.read_count;
					stop = 1'b0;
					while (remaining != 0 && !stop) begin
						pos = (pkt_pos == 2'd3) ? POS_BUTTONS : pkt_pos;
						case (pos)
							POS_BUTTONS: begin
								b = {5'd0, btn_latch};
								if (acc_x < 0) b[XSIGN_BIT] = 1'b1;
								if (acc_y < 0) b[YSIGN_BIT] = 1'b1;
								btn_latch = '0;
								pkt_pos = POS_X;
							end
							POS_X: begin
								b = acc_x[7:0];
								acc_x = '0;
								pkt_pos = POS_Y;
							end
							default: begin
								b = acc_y[7:0];
								acc_y = '0;
								pkt_pos = POS_BUTTONS;
								stop = 1'b1;
							end
						endcase
						r = '{out_kind: KIND_BYTE, out_byte: b, byte_index: pos,
							open_status: STATUS_OK, last: (remaining == 2'd1) || stop,
							data_ready: ready};
						ps2_result_q.push_back(r);
						remaining = remaining - 2'd1;
					end
				end
			end
			REQ_OPEN: begin
				status = STATUS_OK;
				if (!dev_present) begin
					status = STATUS_NODEV;
				end else begin
					if (open_cnt == 0) begin
						btn_latch = '0;
						acc_x = '0;
						acc_y = '0;
					end
					if (open_cnt != OPEN_MAX) open_cnt = open_cnt + 8'd1;
				end
				r = '{out_kind: KIND_OPEN, out_byte: 8'd0, byte_index: POS_BUTTONS,
					open_status: status, last: 1'b1, data_ready: ready};
				ps2_result_q.push_back(r);
			end
			default: begin
				if (open_cnt != 0) open_cnt = open_cnt - 8'd1;
			end
		endcase
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (ps2_result_q.size() == 0) begin
			report_mismatch($sformatf("result %h arrived with none expected", got));
		end else begin
			want = ps2_result_q.pop_front();
			if (got.out_kind !== want.out_kind)
				report_mismatch($sformatf("out_kind %b, expected %b",
					got.out_kind, want.out_kind));
			if (got.out_byte !== want.out_byte)
				report_mismatch($sformatf("out_byte %h, expected %h",
					got.out_byte, want.out_byte));
			if (got.byte_index !== want.byte_index)
				report_mismatch($sformatf("byte_index %0d, expected %0d",
					got.byte_index, want.byte_index));
			if (got.open_status !== want.open_status)
				report_mismatch($sformatf("open_status %b, expected %b",
					got.open_status, want.open_status));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
			if (got.data_ready !== want.data_ready)
				report_mismatch($sformatf("data_ready %b, expected %b",
					got.data_ready, want.data_ready));
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			dev_present = 1'b0;
			open_cnt = '0;
			btn_latch = '0;
			acc_x = '0;
			acc_y = '0;
			pkt_pos = POS_BUTTONS;
			ready = 1'b0;
			leftover_checked = 1'b0;
			ps2_result_q.delete();
			outstanding = 0;
			fail_count = 0;
		end else begin
			if (rsp_valid && !rsp_stall) check_result(rsp);
			if (cfg_we) dev_present = cfg_data;
			if (req_valid && !req_stall) apply_host_request(req);
			if (drain_done && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (ps2_result_q.size() != 0)
					report_mismatch($sformatf("%0d expected results never arrived",
						ps2_result_q.size()));
			end
			outstanding = ps2_result_q.size();
		end
	end

endmodule

/* tb/sv/tb_hid_mouse_to_ps2_packet_top.sv */
// Testbench top that drives host requests into the mouse packet converter and gives the verdict.
module tb_hid_mouse_to_ps2_packet_top;
	import hmp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic      cfg_data = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;
	logic      drain_done = 1'b0;
	int        outstanding;
	int        fail_count;
	int        sender_idle_pct = 0;
	int        rsp_stall_pct = 0;
	int        cycle_count = 0;

	hid_mouse_to_ps2_packet_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	hmp_packet_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.drain_done  (drain_done),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** hid_mouse_to_ps2_packet_top: FAILED **");
			$finish;
		end
	end

	task automatic send_request(input req_t op, input logic [2:0] buttons,
		input logic [7:0] dx, input logic [7:0] dy, input logic [1:0] count);
		in_item_t it;
		it.req_type = op;
		it.report_buttons = buttons;
		it.report_dx = dx;
		it.report_dy = dy;
		it.read_count = count;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(input req_t op);
		send_request(op, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
	endtask

	task automatic wait_quiet();
		req_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_present(input logic value);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic req_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return REQ_REPORT;
		if (r < 75) return REQ_READ;
		if (r < 89) return REQ_OPEN;
		return REQ_CLOSE;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_present(1'b0);
		send_request(REQ_REPORT, 3'd7, 8'h7F, 8'h80, 2'd3);
		send_request(REQ_READ, 3'd0, 8'h00, 8'h00, 2'd3);
		send_request(REQ_OPEN, 3'd7, 8'hFF, 8'hFF, 2'd3);
		send_request(REQ_CLOSE, 3'd0, 8'h00, 8'h00, 2'd0);
		send_request(REQ_READ, 3'd7, 8'hFF, 8'hFF, 2'd0);
		wait_quiet();
		write_present(1'b1);
		send_request(REQ_OPEN, 3'd0, 8'h00, 8'h00, 2'd0);
		send_request(REQ_REPORT, 3'd5, 8'h7F, 8'h80, 2'd0);
		send_request(REQ_READ, 3'd0, 8'h00, 8'h00, 2'd1);
		send_request(REQ_READ, 3'd0, 8'h00, 8'h00, 2'd3);
		send_request(REQ_REPORT, 3'd2, 8'h80, 8'h7F, 2'd3);
		send_request(REQ_READ, 3'd0, 8'h00, 8'h00, 2'd2);
		send_request(REQ_REPORT, 3'd7, 8'hFF, 8'h01, 2'd0);
		send_request(REQ_READ, 3'd0, 8'h00, 8'h00, 2'd1);
		send_request(REQ_READ, 3'd0, 8'h00, 8'h00, 2'd3);
		send_request(REQ_OPEN, 3'd0, 8'h00, 8'h00, 2'd0);
		send_request(REQ_CLOSE, 3'd0, 8'h00, 8'h00, 2'd0);
		send_request(REQ_REPORT, 3'd0, 8'h00, 8'h00, 2'd0);
		send_request(REQ_READ, 3'd0, 8'h00, 8'h00, 2'd0);
		send_request(REQ_REPORT, 3'd6, 8'h40, 8'hC0, 2'd0);
		send_request(REQ_CLOSE, 3'd0, 8'h00, 8'h00, 2'd0);
		send_request(REQ_REPORT, 3'd1, 8'h11, 8'h22, 2'd0);
		send_request(REQ_OPEN, 3'd0, 8'h00, 8'h00, 2'd0);
		send_request(REQ_READ, 3'd0, 8'h00, 8'h00, 2'd3);
		wait_quiet();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 65;
					rsp_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					rsp_stall_pct = 65;
				end
				default: begin
					sender_idle_pct = 10;
					rsp_stall_pct = 10;
				end
			endcase
			write_present(phase != 2);
			send_random(REQ_OPEN);
			repeat (72) send_random(pick_op());
			wait_quiet();
		end

		rsp_stall_pct = 0;
		repeat (20) @(negedge clk);
		drain_done <= 1'b1;
		repeat (2) @(negedge clk);
		if (fail_count == 0) begin
			$display("** hid_mouse_to_ps2_packet_top: PASSED **");
		end else begin
			$display("** hid_mouse_to_ps2_packet_top: FAILED **");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/hmp_pkg.sv
rtl/hmp_front.sv
rtl/hmp_queue.sv
rtl/hmp_back.sv
rtl/hid_mouse_to_ps2_packet_top.sv
tb/sv/hmp_packet_checker.sv
tb/sv/tb_hid_mouse_to_ps2_packet_top.sv
